/* hw/rtl/assert_macros.svh */
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/rdq_pkg.sv */
// shared types and constants of the ring deque
package rdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int ACT_W     = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST       = 3'd4,
    ACT_QAPPEND    = 3'd5
  } act_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic list_init;
    logic rd;
    logic emit_empty;
    logic emit_quiet;
  } rdq_cmd_t;

  typedef struct packed {
    act_t act;
    logic full;
    logic empty;
    logic rd_end;
  } rdq_stat_t;

endpackage

/* hw/rtl/rdq_ram.sv */
// generic simple dual-port ram with registered read
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rdq_ctrl.sv */
// controller of the ring deque: operation and listing sequencer
module rdq_ctrl import rdq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rdq_stat_t stat,
  output rdq_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LIST} state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.act == ACT_QAPPEND) begin
          cmd.emit_quiet = stat.full;
          state_next     = S_IDLE;
        end else if (stat.act == ACT_PUSH_FRONT || stat.act == ACT_PUSH_BACK ||
                     stat.act == ACT_POP_FRONT || stat.act == ACT_POP_BACK ||
                     stat.act == ACT_LIST) begin
          cmd.list_init = 1'b1;
          state_next    = S_LIST;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.empty) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.rd = 1'b1;
          if (stat.rd_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* hw/rtl/rdq_dp.sv */
// datapath of the ring deque: pointers, ram addressing and result register
module rdq_dp import rdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [VAL_W-1:0] value,
  input  rdq_cmd_t                cmd,
  output rdq_stat_t               stat,
  output logic                    ram_we,
  output logic [IW-1:0]           ram_waddr,
  output logic [VAL_W-1:0]        ram_wdata,
  output logic [IW-1:0]           ram_raddr,
  input  logic [VAL_W-1:0]        ram_rdata,
  output logic                    res_valid,
  output logic signed [VAL_W-1:0] value_res,
  output logic                    backward,
  output logic                    empty_res,
  output logic                    rejected,
  output logic                    last
);

  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] TOP_SLOT = IW'(DEPTH - 1);

  act_t             act;
  logic [VAL_W-1:0] val;
  logic [IW-1:0]    front;
  logic [CW-1:0]    count;
  logic [IW-1:0]    off;
  logic             dir;
  logic             rej;
  logic             from_ram;
  logic             full;
  logic             empty;
  logic [IW-1:0]    front_dec;
  logic [IW-1:0]    back_slot;
  logic [IW-1:0]    cnt_last;

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[IW-1:0];
  endfunction

  assign full      = (count == DEPTH_C);
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? TOP_SLOT : front - IW'(1);
  // count is below DEPTH whenever a push writes, so it fits the index width
  assign back_slot = wrap_add(front, count[IW-1:0]);
  assign cnt_last  = count[IW-1:0] - IW'(1);

  assign stat.act    = act;
  assign stat.full   = full;
  assign stat.empty  = empty;
  assign stat.rd_end = dir && (off == '0);

  assign ram_we    = cmd.exec && !full &&
                     (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK || act == ACT_QAPPEND);
  assign ram_waddr = (act == ACT_PUSH_FRONT) ? front_dec : back_slot;
  assign ram_wdata = val;
  assign ram_raddr = wrap_add(front, off);

  assign value_res = from_ram ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= act_t'(action);
      val <= value;
    end
    if (cmd.exec) begin
      rej <= full && (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK);
    end
    if (cmd.list_init) begin
      off <= '0;
      dir <= 1'b0;
    end else if (cmd.rd) begin
      if (!dir) begin
        if (off == cnt_last) begin
          dir <= 1'b1;
        end else begin
          off <= off + IW'(1);
        end
      end else begin
        off <= off - IW'(1);
      end
    end
  end

  // ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      unique case (act)
        ACT_PUSH_FRONT: begin
          if (!full) begin
            front <= front_dec;
            count <= count + CW'(1);
          end
        end
        ACT_PUSH_BACK, ACT_QAPPEND: begin
          if (!full) begin
            count <= count + CW'(1);
          end
        end
        ACT_POP_FRONT: begin
          if (!empty) begin
            front <= wrap_add(front, IW'(1));
            count <= count - CW'(1);
          end
        end
        ACT_POP_BACK: begin
          if (!empty) begin
            count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      from_ram  <= 1'b0;
      backward  <= 1'b0;
      empty_res <= 1'b0;
      rejected  <= 1'b0;
      last      <= 1'b0;
    end else begin
      res_valid <= cmd.rd || cmd.emit_empty || cmd.emit_quiet;
      from_ram  <= cmd.rd;
      backward  <= cmd.rd && dir;
      empty_res <= cmd.emit_empty;
      rejected  <= cmd.emit_quiet || ((cmd.rd || cmd.emit_empty) && rej);
      last      <= cmd.emit_quiet || cmd.emit_empty || (cmd.rd && dir && off == '0);
    end
  end

endmodule

/* hw/rtl/ring_deque_with_listing.sv */
// top level of the ring deque with listing
//
//  channel   handshake              payload
//  command   start / busy           action, value
//  result    res_valid (strobe)     value_res, backward, empty_res, rejected, last
//
// an operation is loaded, then executed; a listing then issues one ram read a cycle
// a deque of n entries lists 2n results, one per cycle; an empty one gives one
// after execute, the first read passes the ram read register and the result register
// busy falls when the last read is issued; reset clears pointers, not the ram
// results are strobed for one cycle and cannot be held off
module ring_deque_with_listing import rdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [VAL_W-1:0] value,
  output logic                    busy,
  output logic                    res_valid,
  output logic signed [VAL_W-1:0] value_res,
  output logic                    backward,
  output logic                    empty_res,
  output logic                    rejected,
  output logic                    last
);

  localparam int IW = $clog2(DEPTH);

  rdq_cmd_t         cmd;
  rdq_stat_t        stat;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  rdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rdq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .action    (action),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .value_res (value_res),
    .backward  (backward),
    .empty_res (empty_res),
    .rejected  (rejected),
    .last      (last)
  );

  rdq_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* hw/rtl/rdq_checker.sv */
// port-level checker of the ring deque and its bind
`include "assert_macros.svh"

module rdq_port_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic res_valid,
  input logic empty_res,
  input logic rejected,
  input logic last
);

  // results only while working or just after the operation ends
  `CHK_IMPLY(a_res_in_op, clk, rst, res_valid, busy || $past(busy), "result outside an operation")
  `CHK_IMPLY(a_empty_last, clk, rst, res_valid && empty_res, last, "empty result not last")
  `CHK_IMPLY(a_rej_not_empty, clk, rst, res_valid && rejected, !empty_res, "reject on empty deque")
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy, "transfer did not raise busy")
  `CHK_NEXT(a_gap_after_last, clk, rst, res_valid && last, !res_valid, "result right after last")

endmodule

bind ring_deque_with_listing rdq_port_checker u_rdq_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .res_valid (res_valid),
  .empty_res (empty_res),
  .rejected  (rejected),
  .last      (last)
);

/* verif/rdq_checker.sv */
// checker for the ring deque: predicts each listing and compares every result transfer
`timescale 1ns / 100ps
module rdq_checker import rdq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    res_valid,
  input  logic signed [VAL_W-1:0] value_res,
  input  logic                    backward,
  input  logic                    empty_res,
  input  logic                    rejected,
  input  logic                    last,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    bw;
    logic                    em;
    logic                    rj;
    logic                    ls;
  } listing_t;

  logic signed [VAL_W-1:0] ring_mem [DEPTH];
  int unsigned             head_idx;
  int unsigned             fill_level;
  listing_t                listing_expected [$];

  function automatic int unsigned ring_pos(int unsigned offset);
    return (head_idx + offset) % DEPTH;
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic queue_listing(logic rj);
    listing_t r;
    if (fill_level == 0) begin
      r = '{val: '0, bw: 1'b0, em: 1'b1, rj: rj, ls: 1'b1};
      listing_expected.push_back(r);
    end else begin
      for (int i = 0; i < fill_level; i++) begin
        r = '{val: ring_mem[ring_pos(i)], bw: 1'b0, em: 1'b0, rj: rj, ls: 1'b0};
        listing_expected.push_back(r);
      end
      for (int i = 0; i < fill_level; i++) begin
        r = '{val: ring_mem[ring_pos(fill_level - 1 - i)], bw: 1'b1, em: 1'b0, rj: rj,
              ls: (i + 1 == fill_level)};
        listing_expected.push_back(r);
      end
    end
  endtask

  task automatic apply_deque_op(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val);
    logic     full;
    listing_t r;
    full = (fill_level >= DEPTH);
    case (act)
      ACT_PUSH_FRONT: begin
        if (!full) begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          ring_mem[head_idx] = val;
          fill_level++;
        end
        queue_listing(full);
      end
      ACT_PUSH_BACK: begin
        if (!full) begin
          ring_mem[ring_pos(fill_level)] = val;
          fill_level++;
        end
        queue_listing(full);
      end
      ACT_POP_FRONT: begin
        if (fill_level != 0) begin
          head_idx = ring_pos(1);
          fill_level--;
        end
        queue_listing(1'b0);
      end
      ACT_POP_BACK: begin
        if (fill_level != 0) fill_level--;
        queue_listing(1'b0);
      end
      ACT_LIST: begin
        queue_listing(1'b0);
      end
      ACT_QAPPEND: begin
        if (full) begin
          r = '{val: '0, bw: 1'b0, em: 1'b0, rj: 1'b1, ls: 1'b1};
          listing_expected.push_back(r);
        end else begin
          ring_mem[ring_pos(fill_level)] = val;
          fill_level++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    listing_t want;
    if (rst) begin
      head_idx   = 0;
      fill_level = 0;
      listing_expected.delete();
    end else begin
      if (res_valid) begin
        if (listing_expected.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d bw %b em %b rj %b last %b",
                                 value_res, backward, empty_res, rejected, last));
        end else begin
          want = listing_expected.pop_front();
          if (value_res !== want.val || backward !== want.bw || empty_res !== want.em ||
              rejected !== want.rj || last !== want.ls)
            note_failure($sformatf({"mismatch: expected value %0d bw %b em %b rj %b last %b,",
                                    " got value %0d bw %b em %b rj %b last %b"},
                                   want.val, want.bw, want.em, want.rj, want.ls,
                                   value_res, backward, empty_res, rejected, last));
        end
      end
      if (start && !busy) apply_deque_op(action, value);
    end
    pending = listing_expected.size();
  end

endmodule

/* verif/testbench.sv */
// testbench top: drives deque commands beside the checker and gives the verdict
`timescale 1ns / 100ps
module testbench;
  import rdq_pkg::*;

  localparam int               DEPTH      = DEPTH_DEF;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic                    clk    = 1'b0;
  logic                    rst    = 1'b1;
  logic                    start  = 1'b0;
  logic [ACT_W-1:0]        action = '0;
  logic signed [VAL_W-1:0] value  = '0;
  logic                    busy;
  logic                    res_valid;
  logic signed [VAL_W-1:0] value_res;
  logic                    backward;
  logic                    empty_res;
  logic                    rejected;
  logic                    last;
  int                      fail_count;
  int                      pending;
  int                      ops_sent;
  int                      burst_kind;
  int                      burst_len;
  int                      pick;
  bit                      calm;
  logic [ACT_W-1:0]        act;

  always #10 clk = ~clk;

  ring_deque_with_listing #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .action   (action),
    .value    (value),
    .busy     (busy),
    .res_valid(res_valid),
    .value_res(value_res),
    .backward (backward),
    .empty_res(empty_res),
    .rejected (rejected),
    .last     (last)
  );

  rdq_checker #(.DEPTH(DEPTH)) u_check (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .action    (action),
    .value     (value),
    .res_valid (res_valid),
    .value_res (value_res),
    .backward  (backward),
    .empty_res (empty_res),
    .rejected  (rejected),
    .last      (last),
    .fail_count(fail_count),
    .pending   (pending)
  );

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one command transfer, waits until busy is seen low and returns at the next falling edge
  task automatic send_op(logic [ACT_W-1:0] a, logic signed [VAL_W-1:0] v);
    start  <= 1'b1;
    action <= a;
    value  <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(bit quiet);
    int n;
    n = 0;
    if (!quiet) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: n = 0;
        9:             n = $urandom_range(10, 40);
        default:       n = $urandom_range(1, 3);
      endcase
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_directed(logic [ACT_W-1:0] a, logic signed [VAL_W-1:0] v);
    send_op(a, v);
    idle_gap(1'b0);
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_directed(ACT_LIST,       pick_value());
    send_directed(ACT_POP_FRONT,  pick_value());
    send_directed(ACT_POP_BACK,   pick_value());
    send_directed(ACT_PUSH_FRONT, VAL_MIN);
    send_directed(ACT_PUSH_BACK,  VAL_MAX);
    send_directed(ACT_SPARE6,     pick_value());
    send_directed(ACT_SPARE7,     pick_value());
    for (int i = 0; i < DEPTH - 2; i++)
      send_directed(ACT_QAPPEND, (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA);
    send_directed(ACT_PUSH_FRONT, '0);
    send_directed(ACT_PUSH_BACK,  '1);
    send_directed(ACT_QAPPEND,    pick_value());
    send_directed(ACT_POP_FRONT,  pick_value());
    send_directed(ACT_POP_BACK,   pick_value());

    ops_sent = 0;
    while (ops_sent < 155) begin
      burst_kind = $urandom_range(0, 9);
      burst_len  = (burst_kind == 9) ? $urandom_range(1, 3) : $urandom_range(1, 24);
      calm       = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len; k++) begin
        pick = $urandom_range(0, 9);
        case (burst_kind)
          0, 1, 2, 3: begin
            case (pick)
              0, 1, 2, 3: act = ACT_QAPPEND;
              4, 5:       act = ACT_PUSH_FRONT;
              6, 7:       act = ACT_PUSH_BACK;
              8:          act = ACT_LIST;
              default:    act = ACT_POP_FRONT;
            endcase
          end
          4, 5, 6: begin
            case (pick)
              0, 1, 2, 3: act = ACT_POP_FRONT;
              4, 5, 6, 7: act = ACT_POP_BACK;
              8:          act = ACT_LIST;
              default:    act = ACT_PUSH_BACK;
            endcase
          end
          7, 8:    act = ACT_W'($urandom_range(ACT_PUSH_FRONT, ACT_QAPPEND));
          default: act = (pick < 5) ? ACT_SPARE6 : ACT_SPARE7;
        endcase
        send_op(act, pick_value());
        if (act != ACT_SPARE6 && act != ACT_SPARE7) ops_sent++;
        idle_gap(calm);
      end
    end
    start <= 1'b0;

    for (int w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
